/* design/tmcr_pkg.sv */
`timescale 1ns / 1ps
package tmcr_pkg;

    localparam int TILE_W  = 8;
    localparam int TILE_H  = 8;
    localparam int COLUMNS = 40;
    localparam int ROWS    = 30;
    localparam int SCALE   = 2;
    localparam int GLYPHS  = 256;

    localparam int GLYPH_BITS  = TILE_W * TILE_H;
    localparam int LOGICAL_W   = COLUMNS * TILE_W;
    localparam int LOGICAL_H   = ROWS * TILE_H;
    localparam int TILES       = COLUMNS * ROWS;
    localparam int FRAME_DEPTH = LOGICAL_W * LOGICAL_H;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int GLYPH_DEPTH = GLYPHS * GLYPH_BITS;
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
    localparam int STEP_W      = (GLYPH_BITS > 1) ? $clog2(GLYPH_BITS) : 1;
    localparam int COL_W       = (TILE_W > 1) ? $clog2(TILE_W) : 1;
    localparam int ROW_STRIDE  = TILE_H * LOGICAL_W;
    localparam int ROW_JUMP    = LOGICAL_W - TILE_W + 1;

    localparam int POS_W     = 11;
    localparam int DIV_SHIFT = POS_W + $clog2(COLUMNS);
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + COLUMNS - 1) / COLUMNS;
    localparam int PROD_W    = DIV_SHIFT + POS_W;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [3:0] BLACK_INDEX = 4'd15;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic                en;
        logic [GLYPH_AW-1:0] addr;
        logic                data;
    } t_glyph_wr;

    typedef struct packed {
        logic                en;
        logic [FRAME_AW-1:0] addr;
        logic [4:0]          data;
    } t_frame_wr;

    function automatic t_rgb palette_lookup(input logic [3:0] idx);
        t_rgb c;
        case (idx)
            4'd0:    c = '{8'd255, 8'd255, 8'd255};
            4'd1:    c = '{8'd165, 8'd42,  8'd42};
            4'd2:    c = '{8'd0,   8'd255, 8'd0};
            4'd3:    c = '{8'd120, 8'd130, 8'd30};
            4'd4:    c = '{8'd30,  8'd50,  8'd130};
            4'd5:    c = '{8'd132, 8'd42,  8'd120};
            4'd6:    c = '{8'd0,   8'd127, 8'd127};
            4'd7:    c = '{8'd178, 8'd178, 8'd178};
            4'd8:    c = '{8'd188, 8'd188, 8'd188};
            4'd9:    c = '{8'd255, 8'd0,   8'd0};
            4'd10:   c = '{8'd198, 8'd198, 8'd50};
            4'd11:   c = '{8'd255, 8'd255, 8'd0};
            4'd12:   c = '{8'd0,   8'd0,   8'd255};
            4'd13:   c = '{8'd255, 8'd27,  8'd170};
            4'd14:   c = '{8'd120, 8'd200, 8'd135};
            default: c = '{8'd0,   8'd0,   8'd0};
        endcase
        return c;
    endfunction

endpackage

/* design/tmcr_glyph_store.sv */
`timescale 1ns / 1ps
module tmcr_glyph_store (
    input  logic                           i_clk,
    input  tmcr_pkg::t_glyph_wr            i_wr,
    input  logic [tmcr_pkg::GLYPH_AW-1:0]  i_raddr,
    output logic                           o_rdata
);

    logic r_mem [tmcr_pkg::GLYPH_DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tmcr_frame_store.sv */
`timescale 1ns / 1ps
module tmcr_frame_store (
    input  logic                           i_clk,
    input  tmcr_pkg::t_frame_wr            i_wr,
    input  logic [tmcr_pkg::FRAME_AW-1:0]  i_raddr,
    output logic [4:0]                     o_rdata
);

    logic [4:0] r_mem [tmcr_pkg::FRAME_DEPTH];
    logic [4:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/text_mode_char_renderer.sv */
`timescale 1ns / 1ps
// Text-mode character renderer.
// Command channel: an item transfers on a rising edge with start high and busy
// low. i_operation selects load glyph bit, draw character or read pixel.
// Result channel: only a pixel read gives a result. o_strobe is high for one
// cycle with RGB and alpha; the receiver cannot stall it.
// Operations:
//   load glyph bit - written at the transfer edge, busy stays low.
//   draw character - busy throughout: S_DIV, S_BASE and S_BASE2 split the tile
//     position into row and column (reciprocal multiply), then one glyph bit read and
//     one frame store write per cycle, and S_TAIL retires the last write.
//   read pixel     - busy for one cycle; o_strobe is registered after the frame store read.
// The draw rate is set by the single write port of the frame store.
// Reset: synchronous, active low. Afterwards the frame store is swept to zero,
// one entry a cycle with busy high. Glyph bits are not cleared and must be
// loaded before a draw uses them.
module text_mode_char_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_glyph_code,
    input  logic [5:0]  i_glyph_bit_index,
    input  logic        i_glyph_bit,
    input  logic [11:0] i_char_word,
    input  logic [10:0] i_tile_position,
    input  logic [9:0]  i_window_x,
    input  logic [8:0]  i_window_y,
    output logic        o_strobe,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_BASE2 = 3'd4;
    localparam logic [2:0] S_DRAW  = 3'd5;
    localparam logic [2:0] S_TAIL  = 3'd6;
    localparam logic [2:0] S_READ  = 3'd7;

    localparam int FAW = tmcr_pkg::FRAME_AW;
    localparam int GAW = tmcr_pkg::GLYPH_AW;
    localparam int PW  = tmcr_pkg::POS_W;
    localparam int SW  = tmcr_pkg::STEP_W;
    localparam int CW  = tmcr_pkg::COL_W;

    logic [2:0]          r_state, n_state;
    logic [FAW-1:0]      r_clr, n_clr;
    logic [PW-1:0]       r_pos, n_pos;
    logic [PW-1:0]       r_quot, n_quot;
    logic [PW-1:0]       r_tcol, n_tcol;
    logic [7:0]          r_code, n_code;
    logic [3:0]          r_color, n_color;
    logic [GAW-1:0]      r_gbase, n_gbase;
    logic [FAW-1:0]      r_fptr, n_fptr;
    logic [SW-1:0]       r_step, n_step;
    logic [CW-1:0]       r_col, n_col;
    logic                r_pend, n_pend;
    logic [FAW-1:0]      r_waddr, n_waddr;
    logic                r_rd_ok, n_rd_ok;
    logic                r_strobe, n_strobe;
    tmcr_pkg::t_rgb      r_rgb, n_rgb;
    logic [7:0]          r_alpha, n_alpha;

    logic                    accept;
    logic [tmcr_pkg::PROD_W-1:0] prod;
    logic [9:0]              scaled_x;
    logic [8:0]              scaled_y;
    tmcr_pkg::t_glyph_wr     glyph_wr;
    tmcr_pkg::t_frame_wr     frame_wr;
    logic [GAW-1:0]          glyph_raddr;
    logic [FAW-1:0]          frame_raddr;
    logic                    glyph_rdata;
    logic [4:0]              frame_rdata;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign prod     = tmcr_pkg::PROD_W'(r_pos) * tmcr_pkg::PROD_W'(tmcr_pkg::DIV_MULT);
    assign scaled_x = 10'(i_window_x / tmcr_pkg::SCALE);
    assign scaled_y = 9'(i_window_y / tmcr_pkg::SCALE);

    always_comb begin
        glyph_wr.en   = accept && (i_operation == tmcr_pkg::OP_LOAD)
                        && (32'(i_glyph_code) < tmcr_pkg::GLYPHS)
                        && (32'(i_glyph_bit_index) < tmcr_pkg::GLYPH_BITS);
        glyph_wr.addr = GAW'(32'(i_glyph_code) * tmcr_pkg::GLYPH_BITS
                        + 32'(i_glyph_bit_index));
        glyph_wr.data = i_glyph_bit;
        glyph_raddr   = r_gbase + GAW'(r_step);

        if (r_state == S_CLEAR) begin
            frame_wr.en   = 1'b1;
            frame_wr.addr = r_clr;
            frame_wr.data = 5'd0;
        end else begin
            frame_wr.en   = r_pend;
            frame_wr.addr = r_waddr;
            frame_wr.data = {1'b1, glyph_rdata ? r_color : tmcr_pkg::BLACK_INDEX};
        end
        frame_raddr = FAW'(32'(scaled_y) * tmcr_pkg::LOGICAL_W + 32'(scaled_x));
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_pos    = r_pos;
        n_quot   = r_quot;
        n_tcol   = r_tcol;
        n_code   = r_code;
        n_color  = r_color;
        n_gbase  = r_gbase;
        n_fptr   = r_fptr;
        n_step   = r_step;
        n_col    = r_col;
        n_pend   = 1'b0;
        n_waddr  = r_waddr;
        n_rd_ok  = r_rd_ok;
        n_strobe = 1'b0;
        n_rgb    = r_rgb;
        n_alpha  = r_alpha;

        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == tmcr_pkg::OP_DRAW) begin
                    n_pos   = i_tile_position;
                    n_code  = i_char_word[7:0];
                    n_color = i_char_word[11:8];
                    n_step  = '0;
                    n_col   = '0;
                    if ((32'(i_tile_position) < tmcr_pkg::TILES)
                            && (32'(i_char_word[7:0]) < tmcr_pkg::GLYPHS)) begin
                        n_state = S_DIV;
                    end
                end else if (accept && i_operation == tmcr_pkg::OP_READ) begin
                    n_rd_ok = (32'(scaled_x) < tmcr_pkg::LOGICAL_W)
                              && (32'(scaled_y) < tmcr_pkg::LOGICAL_H);
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                if (r_clr == FAW'(tmcr_pkg::FRAME_DEPTH - 1)) begin
                    n_clr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + FAW'(1);
                end
            end
            S_DIV: begin
                n_quot  = prod[tmcr_pkg::DIV_SHIFT +: PW];
                n_gbase = GAW'(32'(r_code) * tmcr_pkg::GLYPH_BITS);
                n_state = S_BASE;
            end
            S_BASE: begin
                n_tcol  = r_pos - PW'(32'(r_quot) * tmcr_pkg::COLUMNS);
                n_fptr  = FAW'(32'(r_quot) * tmcr_pkg::ROW_STRIDE);
                n_state = S_BASE2;
            end
            S_BASE2: begin
                n_fptr  = r_fptr + FAW'(32'(r_tcol) * tmcr_pkg::TILE_W);
                n_state = S_DRAW;
            end
            S_DRAW: begin
                n_pend  = 1'b1;
                n_waddr = r_fptr;
                if (r_col == CW'(tmcr_pkg::TILE_W - 1)) begin
                    n_col  = '0;
                    n_fptr = r_fptr + FAW'(tmcr_pkg::ROW_JUMP);
                end else begin
                    n_col  = r_col + CW'(1);
                    n_fptr = r_fptr + FAW'(1);
                end
                if (r_step == SW'(tmcr_pkg::GLYPH_BITS - 1)) begin
                    n_step  = '0;
                    n_state = S_TAIL;
                end else begin
                    n_step = r_step + SW'(1);
                end
            end
            S_TAIL: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                n_strobe = 1'b1;
                if (r_rd_ok && frame_rdata[4]) begin
                    n_rgb   = tmcr_pkg::palette_lookup(frame_rdata[3:0]);
                    n_alpha = 8'd255;
                end else begin
                    n_rgb   = '0;
                    n_alpha = 8'd0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_step   <= '0;
            r_col    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_step   <= n_step;
            r_col    <= n_col;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
        r_pos   <= n_pos;
        r_quot  <= n_quot;
        r_tcol  <= n_tcol;
        r_code  <= n_code;
        r_color <= n_color;
        r_gbase <= n_gbase;
        r_fptr  <= n_fptr;
        r_waddr <= n_waddr;
        r_rd_ok <= n_rd_ok;
        r_rgb   <= n_rgb;
        r_alpha <= n_alpha;
    end

    tmcr_glyph_store u_glyph (
        .i_clk   (i_clk),
        .i_wr    (glyph_wr),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    tmcr_frame_store u_frame (
        .i_clk   (i_clk),
        .i_wr    (frame_wr),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    assign o_strobe = r_strobe;
    assign o_red    = r_rgb.red;
    assign o_green  = r_rgb.green;
    assign o_blue   = r_rgb.blue;
    assign o_alpha  = r_alpha;

endmodule

/* design/tmcr_checker.sv */
`timescale 1ns / 1ps
module tmcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_strobe,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha
);

    logic read_xfer;
    assign read_xfer = start && !busy && (i_operation == tmcr_pkg::OP_READ);

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_xfer |-> ##2 o_strobe)
        else $error("read transfer without result");

    a_result_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(read_xfer, 2))
        else $error("result without read transfer");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_alpha == 8'd0) || (o_alpha == 8'd255))
        else $error("alpha not 0 or 255");

    a_undrawn_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_alpha == 8'd0) |-> (o_red == 8'd0) && (o_green == 8'd0)
            && (o_blue == 8'd0))
        else $error("undrawn pixel not black");

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

bind text_mode_char_renderer tmcr_checker u_tmcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_strobe    (o_strobe),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_alpha     (o_alpha)
);

/* bench/text_mode_char_renderer_tb.sv */
`timescale 1ns / 1ps
module text_mode_char_renderer_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 430;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  glyph_code;
        logic [5:0]  bit_idx;
        logic        glyph_bit;
        logic [11:0] char_word;
        logic [10:0] tile_pos;
        logic [9:0]  win_x;
        logic [8:0]  win_y;
    } t_cmd;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_glyph_code;
    logic [5:0]  i_glyph_bit_index;
    logic        i_glyph_bit;
    logic [11:0] i_char_word;
    logic [10:0] i_tile_position;
    logic [9:0]  i_window_x;
    logic [8:0]  i_window_y;
    logic        o_strobe;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;

    // shadow copies of the block's stores
    logic [4:0] frame_model [tmcr_pkg::FRAME_DEPTH];
    logic       glyph_model [tmcr_pkg::GLYPH_DEPTH];
    logic       glyph_seen  [tmcr_pkg::GLYPH_DEPTH];
    int         glyph_fill  [tmcr_pkg::GLYPHS];
    int         ready_glyphs [$];
    int         drawn_tiles  [$];
    t_pixel     expected_pixels [$];

    int errors;
    int items_sent;
    int idle_pct;
    int idle_cycles;

    text_mode_char_renderer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_glyph_code      (i_glyph_code),
        .i_glyph_bit_index (i_glyph_bit_index),
        .i_glyph_bit       (i_glyph_bit),
        .i_char_word       (i_char_word),
        .i_tile_position   (i_tile_position),
        .i_window_x        (i_window_x),
        .i_window_y        (i_window_y),
        .o_strobe          (o_strobe),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_alpha           (o_alpha)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        case (idx)
            4'd0:    return 24'hFFFFFF;
            4'd1:    return 24'hA52A2A;
            4'd2:    return 24'h00FF00;
            4'd3:    return 24'h78821E;
            4'd4:    return 24'h1E3282;
            4'd5:    return 24'h842A78;
            4'd6:    return 24'h007F7F;
            4'd7:    return 24'hB2B2B2;
            4'd8:    return 24'hBCBCBC;
            4'd9:    return 24'hFF0000;
            4'd10:   return 24'hC6C632;
            4'd11:   return 24'hFFFF00;
            4'd12:   return 24'h0000FF;
            4'd13:   return 24'hFF1BAA;
            4'd14:   return 24'h78C887;
            default: return 24'h000000;
        endcase
    endfunction

    function automatic t_cmd random_fields();
        t_cmd c;
        c.op         = 2'($urandom);
        c.glyph_code = 8'($urandom);
        c.bit_idx    = 6'($urandom);
        c.glyph_bit  = 1'($urandom);
        c.char_word  = 12'($urandom);
        c.tile_pos   = 11'($urandom);
        c.win_x      = 10'($urandom);
        c.win_y      = 9'($urandom);
        return c;
    endfunction

    // apply one accepted command to the shadow state; reads queue a pixel
    task automatic model_command(input t_cmd c);
        int     gi;
        int     fi;
        int     base_x;
        int     base_y;
        int     fx;
        int     fy;
        t_pixel px;
        case (c.op)
            tmcr_pkg::OP_LOAD: begin
                if (int'(c.glyph_code) < tmcr_pkg::GLYPHS
                        && int'(c.bit_idx) < tmcr_pkg::GLYPH_BITS) begin
                    gi = int'(c.glyph_code) * tmcr_pkg::GLYPH_BITS + int'(c.bit_idx);
                    glyph_model[gi] = c.glyph_bit;
                    if (!glyph_seen[gi]) begin
                        glyph_seen[gi] = 1'b1;
                        glyph_fill[c.glyph_code]++;
                        if (glyph_fill[c.glyph_code] == tmcr_pkg::GLYPH_BITS)
                            ready_glyphs.push_back(int'(c.glyph_code));
                    end
                end
            end
            tmcr_pkg::OP_DRAW: begin
                if (int'(c.tile_pos) < tmcr_pkg::TILES
                        && int'(c.char_word[7:0]) < tmcr_pkg::GLYPHS) begin
                    base_y = (int'(c.tile_pos) / tmcr_pkg::COLUMNS) * tmcr_pkg::TILE_H;
                    base_x = (int'(c.tile_pos) % tmcr_pkg::COLUMNS) * tmcr_pkg::TILE_W;
                    for (int r = 0; r < tmcr_pkg::TILE_H; r++) begin
                        for (int k = 0; k < tmcr_pkg::TILE_W; k++) begin
                            gi = int'(c.char_word[7:0]) * tmcr_pkg::GLYPH_BITS
                                 + r * tmcr_pkg::TILE_W + k;
                            fi = (base_y + r) * tmcr_pkg::LOGICAL_W + base_x + k;
                            frame_model[fi] = {1'b1, glyph_model[gi] ? c.char_word[11:8]
                                                     : tmcr_pkg::BLACK_INDEX};
                        end
                    end
                    drawn_tiles.push_back(int'(c.tile_pos));
                end
            end
            tmcr_pkg::OP_READ: begin
                px = '0;
                fx = int'(c.win_x) / tmcr_pkg::SCALE;
                fy = int'(c.win_y) / tmcr_pkg::SCALE;
                if (fx < tmcr_pkg::LOGICAL_W && fy < tmcr_pkg::LOGICAL_H) begin
                    fi = fy * tmcr_pkg::LOGICAL_W + fx;
                    if (frame_model[fi][4]) begin
                        {px.red, px.green, px.blue} = palette_rgb(frame_model[fi][3:0]);
                        px.alpha = 8'd255;
                    end
                end
                expected_pixels.push_back(px);
            end
            default: ;
        endcase
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_command(input t_cmd c);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_operation       = c.op;
        i_glyph_code      = c.glyph_code;
        i_glyph_bit_index = c.bit_idx;
        i_glyph_bit       = c.glyph_bit;
        i_char_word       = c.char_word;
        i_tile_position   = c.tile_pos;
        i_window_x        = c.win_x;
        i_window_y        = c.win_y;
        start             = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        model_command(c);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_load(input logic [7:0] code, input logic [5:0] idx,
                             input logic val);
        t_cmd c;
        c            = random_fields();
        c.op         = tmcr_pkg::OP_LOAD;
        c.glyph_code = code;
        c.bit_idx    = idx;
        c.glyph_bit  = val;
        send_command(c);
    endtask

    task automatic send_draw(input logic [3:0] color, input logic [7:0] code,
                             input logic [10:0] pos);
        t_cmd c;
        c           = random_fields();
        c.op        = tmcr_pkg::OP_DRAW;
        c.char_word = {color, code};
        c.tile_pos  = pos;
        send_command(c);
    endtask

    task automatic send_read(input logic [9:0] x, input logic [8:0] y);
        t_cmd c;
        c       = random_fields();
        c.op    = tmcr_pkg::OP_READ;
        c.win_x = x;
        c.win_y = y;
        send_command(c);
    endtask

    task automatic load_glyph(input logic [7:0] code, input logic [63:0] pattern);
        for (int i = 0; i < tmcr_pkg::GLYPH_BITS; i++)
            send_load(code, i[5:0], pattern[i]);
    endtask

    task automatic wait_for_results();
        while (expected_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_blank_frame();
        idle_pct = 0;
        send_read(10'd0, 9'd0);
        send_read(10'd639, 9'd479);
        send_read(10'd640, 9'd0);
        send_read(10'd0, 9'd480);
        send_read(10'd1023, 9'd511);
    endtask

    task automatic test_glyph_load();
        load_glyph(8'd255, 64'h55AA55AA55AA55AA);
        load_glyph(8'd0, 64'h7FFFFFFFFFFFFFFF);
    endtask

    task automatic test_draw_extremes();
        t_cmd c;
        send_draw(4'd0, 8'd255, 11'd0);
        send_draw(4'd15, 8'd0, 11'd1199);
        send_draw(4'd14, 8'd0, 11'd39);
        send_draw(4'd9, 8'd255, 11'd1160);
        // off screen, must leave the frame alone
        send_draw(4'd2, 8'd255, 11'd1200);
        send_draw(4'd11, 8'd0, 11'd2047);
        c    = random_fields();
        c.op = OP_NONE;
        send_command(c);
        send_read(10'd0, 9'd0);
        send_read(10'd3, 9'd1);
        send_read(10'd15, 9'd15);
        send_read(10'd639, 9'd479);
        send_read(10'd638, 9'd464);
        send_read(10'd639, 9'd0);
        send_read(10'd0, 9'd479);
    endtask

    task automatic test_redraw();
        idle_pct = 27;
        wait_for_results();
        send_draw(4'd13, 8'd0, 11'd0);
        send_read(10'd0, 9'd0);
        send_read(10'd14, 9'd14);
        send_read(10'd15, 9'd15);
    endtask

    task automatic random_item();
        int          pick;
        int          tile;
        logic [63:0] pattern;
        t_cmd        c;
        pick = $urandom_range(99);
        if (pick < 3) begin
            pattern = {$urandom, $urandom};
            case ($urandom_range(2))
                0: pattern &= {$urandom, $urandom};
                1: pattern |= {$urandom, $urandom};
                default: ;
            endcase
            load_glyph(8'($urandom), pattern);
        end else if (pick < 22) begin
            send_load(8'($urandom), 6'($urandom), 1'($urandom));
        end else if (pick < 47) begin
            send_draw(4'($urandom),
                      8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]),
                      ($urandom_range(99) < 85)
                          ? 11'($urandom_range(tmcr_pkg::TILES - 1))
                          : 11'($urandom_range(2047, tmcr_pkg::TILES)));
        end else if (pick < 95) begin
            if (drawn_tiles.size() != 0 && $urandom_range(99) < 70) begin
                tile = drawn_tiles[$urandom_range(drawn_tiles.size() - 1)];
                send_read(10'(((tile % tmcr_pkg::COLUMNS) * tmcr_pkg::TILE_W
                               + $urandom_range(tmcr_pkg::TILE_W - 1)) * tmcr_pkg::SCALE
                              + $urandom_range(tmcr_pkg::SCALE - 1)),
                          9'(((tile / tmcr_pkg::COLUMNS) * tmcr_pkg::TILE_H
                               + $urandom_range(tmcr_pkg::TILE_H - 1)) * tmcr_pkg::SCALE
                              + $urandom_range(tmcr_pkg::SCALE - 1)));
            end else begin
                send_read(10'($urandom), 9'($urandom));
            end
        end else begin
            c    = random_fields();
            c.op = OP_NONE;
            send_command(c);
        end
    endtask

    task automatic test_random_traffic();
        int target;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       idle_pct = 0;
                1:       idle_pct = 77;
                default: idle_pct = 27;
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_item();
            wait_for_results();
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                $error("o_strobe with no pixel read pending");
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_red);
                    errors++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_green);
                    errors++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_blue);
                    errors++;
                end
                if (o_alpha !== want.alpha) begin
                    $error("alpha: expected %0d, got %0d", want.alpha, o_alpha);
                    errors++;
                end
            end
        end
    end

    // idle watchdog: any transfer on either side resets it
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_operation       = tmcr_pkg::OP_LOAD;
        i_glyph_code      = '0;
        i_glyph_bit_index = '0;
        i_glyph_bit       = 1'b0;
        i_char_word       = '0;
        i_tile_position   = '0;
        i_window_x        = '0;
        i_window_y        = '0;
        items_sent        = 0;
        idle_pct          = 0;
        for (int i = 0; i < tmcr_pkg::FRAME_DEPTH; i++)
            frame_model[i] = '0;
        for (int i = 0; i < tmcr_pkg::GLYPH_DEPTH; i++) begin
            glyph_model[i] = 1'b0;
            glyph_seen[i]  = 1'b0;
        end
        for (int i = 0; i < tmcr_pkg::GLYPHS; i++)
            glyph_fill[i] = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_blank_frame();
        test_glyph_load();
        test_draw_extremes();
        test_redraw();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
